[src/priority_task_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Priority task scheduler assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTS_ASSERT(label, clk, rst, prop, msg)
`define PTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[src/pts_pkg.sv]
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Event codes, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS_DEF = 8;

  typedef enum logic [2:0] {
    FN_CREATE    = 3'd0,
    FN_DELAY     = 3'd1,
    FN_TICK      = 3'd2,
    FN_START     = 3'd3,
    FN_ISR_ENTER = 3'd4,
    FN_ISR_EXIT  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_TICK
  } state_t;

endpackage

[src/priority_task_scheduler_unit.sv]
// Create, isr enter/exit without a pass, full-table create and unused codes give
//   done in the cycle after the transfer; a scheduling pass or a tick gives done
//   after the walk over all created tasks has ended. The task table is walked one
//   entry a cycle.
// busy falls in the cycle that carries done, so the next transfer may be accepted there;
//   events without a walk transfer every cycle. The receiver cannot stall the result.
// rst clears control state and ready flags; priority and delay stores are not cleared.
// ----------------------------------------------------------------------------
// Priority task scheduler
// Task table with priorities, ready flags and delay counters; a shared
// walker selects the best ready task and counts down delays on each tick.
// ----------------------------------------------------------------------------
`include "priority_task_scheduler_unit_macros.svh"

module priority_task_scheduler_unit
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [7:0]  task_priority,
  input  logic [15:0] delay_ticks,
  output logic        done,
  output logic [2:0]  running_task,
  output logic        rescheduled,
  output logic        table_full,
  output logic [15:0] tick_total
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  logic [7:0]           prio_mem [MAX_TASKS];
  logic [15:0]          dly_mem  [MAX_TASKS];
  logic [MAX_TASKS-1:0] ready_flags;
  logic [CW-1:0]        used_entries;
  logic [IW-1:0]        current_index;
  logic                 started;
  logic [7:0]           nest_depth;
  logic [15:0]          tick_counter;

  logic [CW-1:0] walk_cnt;
  logic          eval_vld;
  logic [IW-1:0] eval_idx;
  logic [7:0]    prio_rd;
  logic [15:0]   dly_rd;
  logic [7:0]    best_prio;
  logic [IW-1:0] best_idx;

  logic          accept, walking, issue, finish;
  logic          is_full, do_create, do_delay, go_pass, go_tick;
  logic          dly_we;
  logic [IW-1:0] dly_wa;
  logic [15:0]   dly_wd;

  assign busy         = (state != ST_IDLE);
  assign running_task = 3'(current_index);
  assign tick_total   = tick_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    accept    = start && (state == ST_IDLE);
    walking   = (state != ST_IDLE);
    issue     = walking && (walk_cnt != used_entries);
    finish    = walking && (walk_cnt == used_entries) && !eval_vld;
    is_full   = 1'b0;
    do_create = 1'b0;
    do_delay  = 1'b0;
    go_pass   = 1'b0;
    go_tick   = 1'b0;
    unique case (func_t'(func))
      FN_CREATE: begin
        if (used_entries == CW'(MAX_TASKS)) begin
          is_full = 1'b1;
        end else begin
          do_create = 1'b1;
          go_pass   = started;
        end
      end
      FN_DELAY: begin
        do_delay = 1'b1;
        go_pass  = 1'b1;
      end
      FN_TICK:      go_tick = 1'b1;
      FN_START:     go_pass = 1'b1;
      FN_ISR_ENTER: go_pass = 1'b0;
      FN_ISR_EXIT:  go_pass = (nest_depth == 8'd1);
      default:      go_pass = 1'b0;
    endcase

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && go_pass) begin
          state_next = ST_PASS;
        end else if (accept && go_tick) begin
          state_next = ST_TICK;
        end
      end
      ST_PASS, ST_TICK: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    dly_we = 1'b0;
    dly_wa = eval_idx;
    dly_wd = dly_rd - 16'd1;
    if (accept && do_create) begin
      dly_we = 1'b1;
      dly_wa = used_entries[IW-1:0];
      dly_wd = 16'd0;
    end else if (accept && do_delay) begin
      dly_we = 1'b1;
      dly_wa = current_index;
      dly_wd = delay_ticks;
    end else if ((state == ST_TICK) && eval_vld && (dly_rd != 16'd0)) begin
      dly_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_create) begin
      prio_mem[used_entries[IW-1:0]] <= task_priority;
    end
    prio_rd <= prio_mem[walk_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd <= dly_mem[walk_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    eval_idx <= walk_cnt[IW-1:0];
    if ((state == ST_PASS) && eval_vld) begin
      if (eval_idx == '0) begin
        best_prio <= prio_rd;
        best_idx  <= '0;
      end else if (ready_flags[eval_idx] && (prio_rd < best_prio)) begin
        best_prio <= prio_rd;
        best_idx  <= eval_idx;
      end
    end else if (accept) begin
      best_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flags   <= '0;
      used_entries  <= '0;
      current_index <= '0;
      started       <= 1'b0;
      nest_depth    <= '0;
      tick_counter  <= '0;
      walk_cnt      <= '0;
      eval_vld      <= 1'b0;
      done          <= 1'b0;
      rescheduled   <= 1'b0;
      table_full    <= 1'b0;
    end else begin
      done     <= (accept && !go_pass && !go_tick) || finish;
      eval_vld <= issue;
      if (accept) begin
        walk_cnt    <= '0;
        rescheduled <= go_pass;
        table_full  <= is_full;
        unique case (func_t'(func))
          FN_CREATE: begin
            if (do_create) begin
              ready_flags[used_entries[IW-1:0]] <= 1'b1;
              used_entries <= used_entries + CW'(1);
            end
          end
          FN_DELAY:  ready_flags[current_index] <= 1'b0;
          FN_TICK:   tick_counter <= tick_counter + 16'd1;
          FN_START:  started <= 1'b1;
          FN_ISR_ENTER: begin
            if (nest_depth != 8'hFF) begin
              nest_depth <= nest_depth + 8'd1;
            end
          end
          FN_ISR_EXIT: begin
            if (nest_depth != 8'd0) begin
              nest_depth <= nest_depth - 8'd1;
            end
          end
          default: started <= started;
        endcase
      end else if (issue) begin
        walk_cnt <= walk_cnt + CW'(1);
      end
      if ((state == ST_TICK) && eval_vld && (dly_rd == 16'd1)) begin
        ready_flags[eval_idx] <= 1'b1;
      end
      if ((state == ST_PASS) && finish) begin
        current_index <= best_idx;
      end
    end
  end

  `PTS_ASSERT(a_accept_progress, clk, rst, (start && !busy) |=> (busy || done), "lost transfer")
  `PTS_ASSERT(a_used_bound, clk, rst, used_entries <= CW'(MAX_TASKS), "task count too large")
  `PTS_ASSERT(a_current_valid, clk, rst, (current_index == '0) || (CW'(current_index) < used_entries), "bad task")
  `PTS_ASSERT(a_eval_in_walk, clk, rst, eval_vld |-> busy, "evaluation outside a walk")
  `PTS_ASSERT(a_full_no_pass, clk, rst, done |-> !(table_full && rescheduled), "refused create ran a pass")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives kernel events through the start/busy handshake, predicts the
// scheduler's selection, tick count and refusal flags, and checks each
// done-strobed result against the prediction in transfer order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam int         LIMIT_CYCLES = 300000;
  localparam int         MIXED_ITEMS  = 465;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        rescheduled;
    logic        table_full;
    logic [15:0] tick_total;
  } sched_result_t;

  class sched_scoreboard;
    bit [7:0]    prio [MAX_TASKS_DEF];
    bit          ready [MAX_TASKS_DEF];
    bit [15:0]   wait_cnt [MAX_TASKS_DEF];
    int unsigned used;
    bit [2:0]    cur;
    bit          started;
    bit [7:0]    nest;
    bit [15:0]   ticks;
    sched_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned passes;
    int unsigned refusals;
    int unsigned seen [8];

    function void select_task();
      int unsigned best;
      best = 0;
      for (int k = 1; k < used; k++)
        if (ready[k] && prio[k] < prio[best]) best = k;
      cur = 3'(best);
    endfunction

    function void note_event(logic [2:0] fn, logic [7:0] p, logic [15:0] d);
      sched_result_t r;
      bit resched;
      bit refused;
      resched = 1'b0;
      refused = 1'b0;
      seen[fn]++;
      case (fn)
        FN_CREATE: begin
          if (used >= MAX_TASKS_DEF) begin
            refused = 1'b1;
          end else begin
            prio[used]     = p;
            ready[used]    = 1'b1;
            wait_cnt[used] = '0;
            used++;
            resched = started;
          end
        end
        FN_DELAY: begin
          ready[cur]    = 1'b0;
          wait_cnt[cur] = d;
          resched = 1'b1;
        end
        FN_TICK: begin
          ticks++;
          for (int k = 0; k < used; k++) begin
            if (wait_cnt[k] != 0) begin
              wait_cnt[k]--;
              if (wait_cnt[k] == 0) ready[k] = 1'b1;
            end
          end
        end
        FN_START: begin
          started = 1'b1;
          resched = 1'b1;
        end
        FN_ISR_ENTER: begin
          if (nest != 8'hFF) nest++;
        end
        FN_ISR_EXIT: begin
          if (nest != 0) begin
            nest--;
            resched = (nest == 0);
          end
        end
        default: ;
      endcase
      if (resched) select_task();
      passes   += resched;
      refusals += refused;
      r.running_task = cur;
      r.rescheduled  = resched;
      r.table_full   = refused;
      r.tick_total   = ticks;
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no transfer pending: running_task %0d", got.running_task);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.running_task !== exp.running_task) begin
        $error("running_task: expected %0d, got %0d", exp.running_task, got.running_task);
        errors++;
      end
      if (got.rescheduled !== exp.rescheduled) begin
        $error("rescheduled: expected %0d, got %0d", exp.rescheduled, got.rescheduled);
        errors++;
      end
      if (got.table_full !== exp.table_full) begin
        $error("table_full: expected %0d, got %0d", exp.table_full, got.table_full);
        errors++;
      end
      if (got.tick_total !== exp.tick_total) begin
        $error("tick_total: expected %0d, got %0d", exp.tick_total, got.tick_total);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  func;
  logic [7:0]  task_priority;
  logic [15:0] delay_ticks;
  logic        done;
  logic [2:0]  running_task;
  logic        rescheduled;
  logic        table_full;
  logic [15:0] tick_total;

  sched_scoreboard sb = new();
  int          cycles = 0;
  int unsigned burst_left = 0;

  priority_task_scheduler_unit #(
    .MAX_TASKS(MAX_TASKS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .task_priority(task_priority),
    .delay_ticks(delay_ticks),
    .done(done),
    .running_task(running_task),
    .rescheduled(rescheduled),
    .table_full(table_full),
    .tick_total(tick_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result({running_task, rescheduled, table_full, tick_total});
  end

  task automatic send_event(logic [2:0] fn, logic [7:0] p, logic [15:0] d);
    @(negedge clk);
    start         <= 1'b1;
    func          <= fn;
    task_priority <= p;
    delay_ticks   <= d;
    do @(posedge clk); while (busy);
    sb.note_event(fn, p, d);
  endtask

  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start         <= 1'b0;
      func          <= 3'($urandom);
      task_priority <= 8'($urandom);
      delay_ticks   <= 16'($urandom);
    end
  endtask

  task automatic paced_event(logic [2:0] fn, logic [7:0] p, logic [15:0] d);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    send_event(fn, p, d);
  endtask

  // Keep real tasks on short delays so they wake again; long or zero delays
  // mostly land on the idle entry.
  function automatic logic [15:0] pick_delay();
    if (sb.cur == 0 || $urandom_range(0, 199) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 10));
  endfunction

  task automatic run_mixed(int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      paced_event(FN_TICK, 8'($urandom), 16'($urandom));
      else if (roll < 67) paced_event(FN_DELAY, 8'($urandom), pick_delay());
      else if (roll < 75) paced_event(FN_ISR_ENTER, 8'($urandom), 16'($urandom));
      else if (roll < 84) paced_event(FN_ISR_EXIT, 8'($urandom), 16'($urandom));
      else if (roll < 92) paced_event(FN_CREATE, 8'($urandom), 16'($urandom));
      else if (roll < 97) paced_event(FN_START, 8'($urandom), 16'($urandom));
      else if (roll < 99) paced_event(FN_UNUSED_LO, 8'($urandom), 16'($urandom));
      else                paced_event(FN_UNUSED_HI, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    func          = FN_CREATE;
    task_priority = '0;
    delay_ticks   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, not started
    send_event(FN_UNUSED_LO, 8'hFF, 16'hFFFF);
    send_event(FN_UNUSED_HI, 8'h00, 16'h0000);
    send_event(FN_ISR_EXIT, 8'($urandom), 16'($urandom));
    send_event(FN_DELAY, 8'($urandom), 16'hFFFF);
    send_event(FN_ISR_ENTER, 8'($urandom), 16'($urandom));
    send_event(FN_ISR_EXIT, 8'($urandom), 16'($urandom));
    send_event(FN_TICK, 8'($urandom), 16'($urandom));
    // build table before start, block idle entry for good
    send_event(FN_CREATE, 8'd255, 16'($urandom));
    send_event(FN_CREATE, 8'd0, 16'($urandom));
    send_event(FN_CREATE, 8'd40, 16'($urandom));
    send_event(FN_DELAY, 8'($urandom), 16'd0);
    send_event(FN_TICK, 8'($urandom), 16'($urandom));
    send_event(FN_START, 8'($urandom), 16'($urandom));
    send_event(FN_DELAY, 8'($urandom), 16'd2);
    send_event(FN_TICK, 8'($urandom), 16'($urandom));
    send_event(FN_TICK, 8'($urandom), 16'($urandom));
    // fill up with ties, then overflow
    send_event(FN_CREATE, 8'd40, 16'($urandom));
    send_event(FN_CREATE, 8'd200, 16'($urandom));
    send_event(FN_CREATE, 8'd255, 16'($urandom));
    send_event(FN_CREATE, 8'd7, 16'($urandom));
    send_event(FN_CREATE, 8'($urandom), 16'($urandom));
    send_event(FN_CREATE, 8'd0, 16'($urandom));
    send_event(FN_CREATE, 8'd255, 16'($urandom));
    send_event(FN_ISR_ENTER, 8'($urandom), 16'($urandom));
    send_event(FN_ISR_EXIT, 8'($urandom), 16'($urandom));

    run_mixed(MIXED_ITEMS);
    // drive nesting past saturation and back down past zero
    repeat (260) paced_event(FN_ISR_ENTER, 8'($urandom), 16'($urandom));
    repeat (257) paced_event(FN_ISR_EXIT, 8'($urandom), 16'($urandom));
    run_mixed(MIXED_ITEMS);

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d creates (%0d refused), %0d delays, %0d ticks, %0d starts,",
             sb.seen[FN_CREATE], sb.refusals, sb.seen[FN_DELAY], sb.seen[FN_TICK],
             sb.seen[FN_START]);
    $display("%0d isr enters, %0d isr exits, %0d unused codes; %0d results, %0d passes.",
             sb.seen[FN_ISR_ENTER], sb.seen[FN_ISR_EXIT],
             sb.seen[FN_UNUSED_LO] + sb.seen[FN_UNUSED_HI], sb.checked, sb.passes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
